### rtl/sspg_pkg.sv
// Shared types, fixed-point constants and the rounding helper for the
// scaled sin(pi*d)/pi sample generator. No dependencies.
`default_nettype none

package sspg_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned FREQ_W = 32;
  localparam int unsigned AMP_W  = 16;
  localparam int unsigned SMP_W  = 16;

  typedef logic signed [TIME_W-1:0] time_t;
  typedef logic signed [FREQ_W-1:0] freq_t;
  typedef logic signed [AMP_W-1:0]  amp_t;
  typedef logic signed [SMP_W-1:0]  smp_t;

  // Polynomial coefficients, rounded to the nearest Q2.30 value.
  localparam logic signed [31:0] COEF_C0 = -32'sd191327726;
  localparam logic signed [31:0] COEF_C1 =  32'sd869588499;
  localparam logic signed [31:0] COEF_C2 = -32'sd1766147568;

  // Half of one Q2.30 step after a Q2.30 by Q2.30 product.
  localparam logic signed [63:0] RND_HALF = 64'sd536870912;

  localparam logic signed [33:0] SMP_MAX = 34'sd32767;
  localparam logic signed [33:0] SMP_MIN = -34'sd32768;

  // Phase stage result: folded Q2.30 remainder, its square and the amplitude.
  typedef struct packed {
    logic signed [30:0] x;
    logic signed [29:0] s;
    amp_t               amp;
  } phase_t;

  // Polynomial stage result: Q2.30 value of sin(pi*r)/pi and the amplitude.
  typedef struct packed {
    logic signed [31:0] y;
    amp_t               amp;
  } poly_t;

  // Round half up of v / 2^30.
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + RND_HALF;
    return t[63:30];
  endfunction

endpackage

`default_nettype wire

### rtl/sspg_in_if.sv
// Input channel of the sample generator: valid/ready handshake with the
// time, frequency and amplitude payload. Depends on sspg_pkg.
`default_nettype none

interface sspg_in_if;
  import sspg_pkg::*;

  logic  valid;
  logic  ready;
  time_t time_value;
  freq_t frequency;
  amp_t  amplitude;

  modport source (output valid, output time_value, output frequency, output amplitude,
                  input ready);
  modport sink   (input valid, input time_value, input frequency, input amplitude,
                  output ready);
endinterface

`default_nettype wire

### rtl/sspg_out_if.sv
// Result channel of the sample generator: valid/ready handshake with one
// signed 16-bit sample. Depends on sspg_pkg.
`default_nettype none

interface sspg_out_if;
  import sspg_pkg::*;

  logic valid;
  logic ready;
  smp_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### rtl/scaled_sinpi_sample_generator_core.sv
// Scaled sin(pi*d)/pi sample generator, top level.
// Throughput: one item per cycle while the output side takes every sample;
// six register stages, one multiplier layer each.
// Reset (rst_n low, synchronous) empties every stage; payload registers keep data.
// Depends on sspg_pkg, sspg_in_if, sspg_out_if, sspg_phase, sspg_poly, sspg_scale.
`default_nettype none

module scaled_sinpi_sample_generator_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sspg_in_if.sink     in_ch,
  sspg_out_if.source  out_ch
);
  import sspg_pkg::*;

  // The datapath is a chain of six stages. Each stage holds a valid bit and
  // takes a new transfer whenever it is empty or its successor takes its
  // current one, so the chain fills completely under backpressure and never
  // drops or repeats a transfer. The ready chain runs back from the output
  // register to the input.
  //
  // Stage A forms the Q32.32 product of time and frequency. Stage B rounds it
  // to the nearest half turn count, folds the remainder by the parity of that
  // count and squares it. Stages C through E evaluate the odd polynomial in
  // Q2.30, and stage F scales by the amplitude, rounds and saturates.

  logic   ph_valid;
  logic   ph_ready;
  phase_t ph_data;

  logic   po_valid;
  logic   po_ready;
  poly_t  po_data;

  sspg_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .time_value (in_ch.time_value),
    .frequency  (in_ch.frequency),
    .amplitude  (in_ch.amplitude),
    .out_valid  (ph_valid),
    .out_ready  (ph_ready),
    .out_data   (ph_data)
  );

  sspg_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .in_data   (ph_data),
    .out_valid (po_valid),
    .out_ready (po_ready),
    .out_data  (po_data)
  );

  sspg_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (po_valid),
    .in_ready   (po_ready),
    .in_data    (po_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample)
  );

  // A downstream that takes every sample never stalls the input side.
  a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled although the output side is ready");

  // With the output register empty, no stage can be full and blocking.
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with an empty output register");

  // Without backpressure and reset, an input transfer always reaches the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_ch.valid && in_ch.ready, 6) &&
     $past(out_ch.ready, 1) && $past(out_ch.ready, 2) && $past(out_ch.ready, 3) &&
     $past(out_ch.ready, 4) && $past(out_ch.ready, 5) && $past(out_ch.ready, 6) &&
     $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) &&
     $past(rst_n, 4) && $past(rst_n, 5) && $past(rst_n, 6)) |-> out_ch.valid)
    else $error("sample missing six cycles after an unstalled input transfer");

endmodule

`default_nettype wire

### rtl/sspg_phase.sv
// Phase front end: Q32.32 product of time and frequency, reduction to the
// folded remainder and its square. Two register stages. Depends on sspg_pkg.
`default_nettype none

module sspg_phase (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sspg_pkg::time_t time_value,
  input  wire sspg_pkg::freq_t frequency,
  input  wire sspg_pkg::amp_t  amplitude,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sspg_pkg::phase_t    out_data
);
  import sspg_pkg::*;

  // Stage A: product, only the low 33 bits matter (parity and fraction).
  logic               a_valid_r;
  logic [32:0]        a_prod_r;
  amp_t               a_amp_r;
  logic signed [63:0] a_prod_nxt;
  logic               a_ready;

  // Stage B: folded remainder and its square.
  logic               b_valid_r;
  phase_t             b_data_r;
  phase_t             b_data_nxt;
  logic               b_ready;

  logic signed [29:0] x_floor;
  logic signed [30:0] x_ext;
  logic               q_odd;
  logic signed [63:0] x_sq;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  assign a_prod_nxt = time_value * frequency;

  // The Q0.32 remainder is the low word of the product taken as signed;
  // q is odd when rounding carries into bit 32 differently from bit 32.
  assign x_floor = a_prod_r[31:2];
  assign x_ext   = {x_floor[29], x_floor};
  assign q_odd   = a_prod_r[32] ^ a_prod_r[31];

  always_comb begin
    b_data_nxt.x   = q_odd ? -x_ext : x_ext;
    x_sq           = b_data_nxt.x * b_data_nxt.x;
    b_data_nxt.s   = 30'(rnd30(x_sq));
    b_data_nxt.amp = a_amp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_valid;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_prod_r <= a_prod_nxt[32:0];
      a_amp_r  <= amplitude;
    end
    if (b_ready && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

`default_nettype wire

### rtl/sspg_poly.sv
// Degree-7 odd polynomial in Q2.30, one multiplier layer per register stage.
// Three register stages. Depends on sspg_pkg.
`default_nettype none

module sspg_poly (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sspg_pkg::phase_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sspg_pkg::poly_t       out_data
);
  import sspg_pkg::*;

  // Stage C: u1 = c0*s + c1 and w = s*x.
  logic               c_valid_r;
  logic signed [30:0] c_x_r;
  logic signed [29:0] c_s_r;
  logic signed [28:0] c_w_r;
  logic signed [31:0] c_u_r;
  amp_t               c_amp_r;
  logic signed [63:0] c_p0;
  logic signed [63:0] c_p1;
  logic signed [33:0] c_u_nxt;
  logic signed [33:0] c_w_nxt;
  logic               c_ready;

  // Stage D: u2 = u1*s + c2.
  logic               d_valid_r;
  logic signed [30:0] d_x_r;
  logic signed [28:0] d_w_r;
  logic signed [31:0] d_u_r;
  amp_t               d_amp_r;
  logic signed [63:0] d_p;
  logic signed [33:0] d_u_nxt;
  logic               d_ready;

  // Stage E: y = w*u2 + x.
  logic               e_valid_r;
  poly_t              e_data_r;
  logic signed [63:0] e_p;
  logic signed [33:0] e_y_nxt;
  logic               e_ready;

  assign e_ready  = !e_valid_r || out_ready;
  assign d_ready  = !d_valid_r || e_ready;
  assign c_ready  = !c_valid_r || d_ready;
  assign in_ready = c_ready;

  always_comb begin
    c_p0    = COEF_C0 * in_data.s;
    c_p1    = in_data.s * in_data.x;
    c_u_nxt = rnd30(c_p0) + 34'(COEF_C1);
    c_w_nxt = rnd30(c_p1);
    d_p     = c_u_r * c_s_r;
    d_u_nxt = rnd30(d_p) + 34'(COEF_C2);
    e_p     = d_w_r * d_u_r;
    e_y_nxt = rnd30(e_p) + 34'(d_x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      if (c_ready) c_valid_r <= in_valid;
      if (d_ready) d_valid_r <= c_valid_r;
      if (e_ready) e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_x_r   <= in_data.x;
      c_s_r   <= in_data.s;
      c_w_r   <= c_w_nxt[28:0];
      c_u_r   <= c_u_nxt[31:0];
      c_amp_r <= in_data.amp;
    end
    if (d_ready && c_valid_r) begin
      d_x_r   <= c_x_r;
      d_w_r   <= c_w_r;
      d_u_r   <= d_u_nxt[31:0];
      d_amp_r <= c_amp_r;
    end
    if (e_ready && d_valid_r) begin
      e_data_r.y   <= e_y_nxt[31:0];
      e_data_r.amp <= d_amp_r;
    end
  end

  assign out_valid = e_valid_r;
  assign out_data  = e_data_r;

endmodule

`default_nettype wire

### rtl/sspg_scale.sv
// Output stage: amplitude scaling, rounding and saturation to 16 bits into
// the output register. One register stage. Depends on sspg_pkg.
`default_nettype none

module sspg_scale (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sspg_pkg::poly_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sspg_pkg::smp_t       out_sample
);
  import sspg_pkg::*;

  logic               f_valid_r;
  smp_t               f_smp_r;
  smp_t               f_smp_nxt;
  logic signed [63:0] f_p;
  logic signed [33:0] f_t;

  assign in_ready = !f_valid_r || out_ready;

  always_comb begin
    f_p = in_data.amp * in_data.y;
    f_t = rnd30(f_p);
    if (f_t > SMP_MAX) begin
      f_smp_nxt = SMP_W'(SMP_MAX);
    end else if (f_t < SMP_MIN) begin
      f_smp_nxt = SMP_W'(SMP_MIN);
    end else begin
      f_smp_nxt = f_t[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_smp_r <= f_smp_nxt;
    end
  end

  assign out_valid  = f_valid_r;
  assign out_sample = f_smp_r;

endmodule

`default_nettype wire
